>>> sv/tdmt_pkg.sv
// Shared types and constants for the transmit descriptor multiplexer and translator.
`default_nettype none

package tdmt_pkg;

    localparam int ADDR_W       = 48;
    localparam int LEN_W        = 12;
    localparam int CLIENT_W     = 2;
    localparam int COUNT_W      = 11;
    localparam int STATUS_W     = 2;
    localparam int REG_INDEX_W  = 2;

    localparam int CLIENT_COUNT_DEFAULT = 3;
    localparam int BUFFER_BYTES         = 2048;
    localparam int BUF_SHIFT            = $clog2(BUFFER_BYTES);
    localparam int SPAN_W               = COUNT_W + BUF_SHIFT;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(512);

    localparam logic [REG_INDEX_W-1:0] REG_BASE_CLIENT0       = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_BASE_CLIENT1       = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_BASE_CLIENT2       = 2'd2;
    localparam logic [REG_INDEX_W-1:0] REG_BUFFERS_PER_REGION = 2'd3;

    localparam logic KIND_CLIENT = 1'b0;
    localparam logic KIND_DRIVER = 1'b1;

    localparam logic DEST_DRIVER = 1'b0;
    localparam logic DEST_CLIENT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ROUTED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOUNCED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_REGION = 2'd2;

    typedef struct packed {
        logic                kind;
        logic [CLIENT_W-1:0] source_client;
        logic [ADDR_W-1:0]   address_in;
        logic [LEN_W-1:0]    length_in;
    } desc_in_t;

    typedef struct packed {
        logic                destination;
        logic [CLIENT_W-1:0] target_client;
        logic [ADDR_W-1:0]   address_out;
        logic [LEN_W-1:0]    length_out;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

>>> sv/tx_descriptor_mux_translate.sv
// Transmit descriptor multiplexer: validates, translates and routes one descriptor per cycle.
//
//  channel      handshake               payload
//  -----------  ----------------------  ------------------------
//  descriptor   start / busy            desc_in_t  descriptor
//  result       done (strobe)           result_t   result
//  config       wr_en                   wr_index, wr_data
//
// One descriptor is taken every cycle; busy stays low.
// After its descriptor is taken, a result passes the input register, then
// region compare and 48-bit add/subtract into the result register.
// Reset clears all client bases to zero and sets buffers per region to 512.
// done is high for one cycle per word; the receiver cannot stall it.
`default_nettype none

module tx_descriptor_mux_translate
    import tdmt_pkg::*;
#(
    parameter int CLIENT_COUNT = CLIENT_COUNT_DEFAULT
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   start,
    output logic                        busy,
    input  wire desc_in_t               descriptor,

    output logic                        done,
    output result_t                     result,

    input  wire logic                   wr_en,
    input  wire logic [REG_INDEX_W-1:0] wr_index,
    input  wire logic [ADDR_W-1:0]      wr_data
);

    logic [ADDR_W-1:0]  base_reg [CLIENT_COUNT];
    logic [COUNT_W-1:0] count_reg;

    desc_in_t           item_reg;
    logic               item_valid_reg;

    result_t            result_reg;
    result_t            result_next;
    logic               done_reg;

    logic [SPAN_W-1:0]  span;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign span   = {count_reg, {BUF_SHIFT{1'b0}}};

    for (genvar c = 0; c < CLIENT_COUNT; c++) begin : g_base
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                base_reg[c] <= '0;
            end
            else if (wr_en && wr_index == REG_INDEX_W'(c))
            begin
                base_reg[c] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (wr_en && wr_index == REG_BUFFERS_PER_REGION)
        begin
            count_reg <= wr_data[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
            done_reg       <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= descriptor;
        end
        if (item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        logic [ADDR_W-1:0] sel_base;
        logic              src_ok;
        logic              aligned;
        logic              in_region;
        logic [ADDR_W:0]   diff;
        logic              found;
        logic [ADDR_W-1:0] hit_offset;
        logic [CLIENT_W-1:0] hit_client;

        sel_base   = '0;
        src_ok     = 1'b0;
        found      = 1'b0;
        hit_offset = '0;
        hit_client = '0;
        diff       = '0;

        for (int c = 0; c < CLIENT_COUNT; c++)
        begin
            if (item_reg.source_client == CLIENT_W'(c))
            begin
                sel_base = base_reg[c];
                src_ok   = 1'b1;
            end
        end

        for (int c = 0; c < CLIENT_COUNT; c++)
        begin
            diff = {1'b0, item_reg.address_in} - {1'b0, base_reg[c]};
            if (!found && !diff[ADDR_W] && diff[ADDR_W-1:SPAN_W] == '0
                && diff[SPAN_W-1:0] < span)
            begin
                found      = 1'b1;
                hit_offset = diff[ADDR_W-1:0];
                hit_client = CLIENT_W'(c);
            end
        end

        aligned   = item_reg.address_in[BUF_SHIFT-1:0] == '0;
        in_region = item_reg.address_in[ADDR_W-1:SPAN_W] == '0
                    && item_reg.address_in[SPAN_W-1:0] < span;

        result_next.length_out = item_reg.length_in;

        if (item_reg.kind == KIND_CLIENT)
        begin
            if (src_ok && aligned && in_region)
            begin
                result_next.destination   = DEST_DRIVER;
                result_next.target_client = '0;
                result_next.address_out   = item_reg.address_in + sel_base;
                result_next.status        = STATUS_ROUTED;
            end
            else
            begin
                result_next.destination   = DEST_CLIENT;
                result_next.target_client = item_reg.source_client;
                result_next.address_out   = item_reg.address_in;
                result_next.status        = STATUS_BOUNCED;
            end
        end
        else if (found)
        begin
            result_next.destination   = DEST_CLIENT;
            result_next.target_client = hit_client;
            result_next.address_out   = hit_offset;
            result_next.status        = STATUS_ROUTED;
        end
        else
        begin
            result_next.destination   = DEST_CLIENT;
            result_next.target_client = '0;
            result_next.address_out   = item_reg.address_in;
            result_next.status        = STATUS_NO_REGION;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_valid_reg)
        else $error("accepted word did not reach the input stage");

    a_stage_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |=> done)
        else $error("staged word produced no result strobe");

    a_driver_routed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.destination == DEST_DRIVER) |->
            (result.status == STATUS_ROUTED && result.target_client == '0))
        else $error("word to driver must be routed to client zero slot");

    a_no_region_client: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_NO_REGION) |->
            (result.destination == DEST_CLIENT && result.target_client == '0))
        else $error("unmatched word must go to client zero free ring");
`endif

endmodule

`default_nettype wire

>>> sim/tx_descriptor_mux_translate_tb.sv
// Testbench for the transmit descriptor multiplexer: directed and random descriptors checked against a local model.
module tx_descriptor_mux_translate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdmt_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 215;
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    desc_in_t               descriptor;
    logic                   done;
    result_t                result;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] wr_index;
    logic [ADDR_W-1:0]      wr_data;

    logic [ADDR_W-1:0]  client_base [3];
    logic [COUNT_W-1:0] region_buffers;
    result_t            pending_results [$];

    int cycle_count;
    int mismatches;
    int words_sent;
    int settings_used;
    int n_forwarded;
    int n_bounced;
    int n_returned;
    int n_unmatched;

    tx_descriptor_mux_translate DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .descriptor (descriptor),
        .done       (done),
        .result     (result),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] region_span();
        return 64'(BUFFER_BYTES) * 64'(region_buffers);
    endfunction

    function automatic result_t route_descriptor(input desc_in_t d);
        result_t     r;
        logic [63:0] span;
        logic [63:0] addr;
        logic [63:0] b;
        bit          valid;
        span = region_span();
        addr = 64'(d.address_in);
        r.length_out = d.length_in;
        if (d.kind == KIND_CLIENT) begin
            valid = (d.source_client < 2'd3) && (addr % BUFFER_BYTES == 0) && (addr < span);
            if (valid) begin
                r.destination   = DEST_DRIVER;
                r.target_client = '0;
                r.address_out   = d.address_in + client_base[d.source_client];
                r.status        = STATUS_ROUTED;
            end
            else begin
                r.destination   = DEST_CLIENT;
                r.target_client = d.source_client;
                r.address_out   = d.address_in;
                r.status        = STATUS_BOUNCED;
            end
            return r;
        end
        for (int c = 0; c < 3; c++) begin
            b = 64'(client_base[c]);
            if (addr >= b && addr - b < span) begin
                r.destination   = DEST_CLIENT;
                r.target_client = CLIENT_W'(c);
                r.address_out   = ADDR_W'(addr - b);
                r.status        = STATUS_ROUTED;
                return r;
            end
        end
        r.destination   = DEST_CLIENT;
        r.target_client = '0;
        r.address_out   = d.address_in;
        r.status        = STATUS_NO_REGION;
        return r;
    endfunction

    function automatic desc_in_t make_word(input logic kind, input logic [CLIENT_W-1:0] src,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [LEN_W-1:0] len);
        desc_in_t d;
        d.kind          = kind;
        d.source_client = src;
        d.address_in    = addr;
        d.length_in     = len;
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return LEN_W'(BUFFER_BYTES);
        return LEN_W'($urandom_range(0, 2047));
    endfunction

    function automatic desc_in_t random_descriptor();
        desc_in_t    d;
        int          sel;
        int          c;
        logic [63:0] span;
        logic [63:0] idx;
        span = region_span();
        sel  = $urandom_range(0, 99);
        d.kind          = logic'($urandom_range(0, 1));
        d.length_in     = random_length();
        d.source_client = ($urandom_range(0, 19) == 0) ? 2'd3 : CLIENT_W'($urandom_range(0, 2));
        if (d.kind == KIND_CLIENT) begin
            idx = (region_buffers == 0) ? 64'd0 : 64'($urandom_range(0, region_buffers - 1));
            if (sel < 70)
                d.address_in = ADDR_W'(idx << BUF_SHIFT);
            else if (sel < 80)
                d.address_in = ADDR_W'((idx << BUF_SHIFT) | 64'($urandom_range(1, 2047)));
            else if (sel < 90)
                d.address_in = ADDR_W'((64'(region_buffers) + 64'($urandom_range(0, 50)))
                                       << BUF_SHIFT);
            else
                d.address_in = random_address();
        end
        else begin
            c = $urandom_range(0, 2);
            if (sel < 70 && span != 0)
                d.address_in = client_base[c] + ADDR_W'($urandom_range(0, span - 1));
            else if (sel < 78)
                d.address_in = client_base[c] + ADDR_W'(span);
            else if (sel < 85)
                d.address_in = client_base[c] - 1'b1;
            else
                d.address_in = random_address();
        end
        return d;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge clk) begin
        result_t exp_r;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
        else if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time, result);
                mismatches++;
            end
            else begin
                exp_r = pending_results.pop_front();
                if (result.destination !== exp_r.destination)
                    report_mismatch("destination", exp_r.destination, result.destination);
                if (result.target_client !== exp_r.target_client)
                    report_mismatch("target_client", exp_r.target_client, result.target_client);
                if (result.address_out !== exp_r.address_out)
                    report_mismatch("address_out", exp_r.address_out, result.address_out);
                if (result.length_out !== exp_r.length_out)
                    report_mismatch("length_out", exp_r.length_out, result.length_out);
                if (result.status !== exp_r.status)
                    report_mismatch("status", exp_r.status, result.status);
                if (exp_r.destination == DEST_DRIVER)
                    n_forwarded++;
                else if (exp_r.status == STATUS_BOUNCED)
                    n_bounced++;
                else if (exp_r.status == STATUS_ROUTED)
                    n_returned++;
                else
                    n_unmatched++;
            end
        end
    end

    task automatic send_descriptor(input desc_in_t d, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      = 1'b1;
        descriptor = d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(route_descriptor(d));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_directed(input desc_in_t d);
        send_descriptor(d, $urandom_range(0, 9));
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [REG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = val;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == REG_BUFFERS_PER_REGION)
            region_buffers = val[COUNT_W-1:0];
        else
            client_base[idx] = val;
    endtask

    task automatic apply_setting(input logic [ADDR_W-1:0] b0, input logic [ADDR_W-1:0] b1,
                                 input logic [ADDR_W-1:0] b2, input logic [COUNT_W-1:0] count);
        wait_drained();
        write_register(REG_BASE_CLIENT0, b0);
        write_register(REG_BASE_CLIENT1, b1);
        write_register(REG_BASE_CLIENT2, b2);
        write_register(REG_BUFFERS_PER_REGION, ADDR_W'(count));
        settings_used++;
    endtask

    task automatic test_reset_values();
        send_directed(make_word(KIND_CLIENT, 2'd0, '0, '0));
        send_directed(make_word(KIND_DRIVER, 2'd0, '0, LEN_W'(BUFFER_BYTES)));
    endtask

    task automatic test_client_descriptors();
        apply_setting(48'h0000_1000_0000, 48'hFFFF_FFFF_F800, 48'h0000_2000_0000, 11'd1024);
        send_directed(make_word(KIND_CLIENT, 2'd0, '0, LEN_W'(BUFFER_BYTES)));
        send_directed(make_word(KIND_CLIENT, 2'd0, ADDR_W'(region_span() - BUFFER_BYTES), 12'd64));
        send_directed(make_word(KIND_CLIENT, 2'd0, ADDR_W'(region_span()), 12'd1));
        send_directed(make_word(KIND_CLIENT, 2'd1, ADDR_W'(BUFFER_BYTES), 12'd1500));
        send_directed(make_word(KIND_CLIENT, 2'd2, 48'd1, 12'd60));
        send_directed(make_word(KIND_CLIENT, 2'd3, '0, 12'd2047));
        send_directed(make_word(KIND_CLIENT, 2'd1, ADDR_MAX, 12'd1024));
    endtask

    task automatic test_returned_descriptors();
        send_directed(make_word(KIND_DRIVER, 2'd0, client_base[0], 12'd100));
        send_directed(make_word(KIND_DRIVER, 2'd0, client_base[0] + ADDR_W'(region_span() - 1),
                                12'd200));
        send_directed(make_word(KIND_DRIVER, 2'd1, client_base[0] + ADDR_W'(region_span()),
                                12'd300));
        send_directed(make_word(KIND_DRIVER, 2'd2, client_base[2] + 48'd12345, 12'd400));
        send_directed(make_word(KIND_DRIVER, 2'd0, ADDR_MAX, 12'd512));
        send_directed(make_word(KIND_DRIVER, 2'd1, '0, 12'd0));
        send_directed(make_word(KIND_DRIVER, 2'd3, client_base[2], 12'd2048));
    endtask

    task automatic test_region_count_extremes();
        apply_setting(48'h0000_1000_0000, 48'hFFFF_FFFF_F800, 48'h0000_2000_0000, 11'd0);
        send_directed(make_word(KIND_CLIENT, 2'd0, '0, 12'd10));
        send_directed(make_word(KIND_DRIVER, 2'd0, client_base[0], 12'd20));
        apply_setting(48'h0000_1000_0000, 48'h0000_1000_0000, 48'h0000_2000_0000, 11'd2047);
        send_directed(make_word(KIND_DRIVER, 2'd0, client_base[0] + 48'd5, 12'd30));
        send_directed(make_word(KIND_CLIENT, 2'd0, ADDR_W'(2046 * BUFFER_BYTES), 12'd40));
        send_directed(make_word(KIND_CLIENT, 2'd0, ADDR_W'(2047 * BUFFER_BYTES), 12'd50));
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] x;
        bit                burst;
        for (int phase = 0; phase < 6; phase++) begin
            x = random_address();
            case (phase)
                0: apply_setting('0, 48'd1048576, x, COUNT_RESET);
                1: apply_setting(random_address(), random_address(), x, 11'd1024);
                2: apply_setting('0, ADDR_MAX, ADDR_MAX - 48'd2047, 11'd1);
                3: apply_setting(x, x - 48'd1048576, x, 11'd2047);
                4: apply_setting(random_address(), random_address(), x, 11'd0);
                default: apply_setting(random_address(), random_address(), x,
                                       COUNT_W'($urandom_range(1, 1024)));
            endcase
            burst = 1'b0;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i % 40 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (i == PHASE_WORDS / 2)
                    wait_drained();
                send_descriptor(random_descriptor(), burst ? 0 : $urandom_range(0, 9));
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        start          = 1'b0;
        descriptor     = '0;
        wr_en          = 1'b0;
        wr_index       = REG_BASE_CLIENT0;
        wr_data        = '0;
        client_base[0] = '0;
        client_base[1] = '0;
        client_base[2] = '0;
        region_buffers = COUNT_RESET;
        cycle_count    = 0;
        mismatches     = 0;
        words_sent     = 0;
        settings_used  = 1;
        n_forwarded    = 0;
        n_bounced      = 0;
        n_returned     = 0;
        n_unmatched    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_client_descriptors();
        test_returned_descriptors();
        test_region_count_extremes();
        test_random_traffic();
        wait_drained();

        $display("%0d descriptors under %0d register settings: %0d forwarded, %0d bounced,",
                 words_sent, settings_used, n_forwarded, n_bounced);
        $display("%0d returned to clients, %0d without a region, %0d mismatches",
                 n_returned, n_unmatched, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
sv/tdmt_pkg.sv
sv/tx_descriptor_mux_translate.sv
sim/tx_descriptor_mux_translate_tb.sv
